// File: rtl/sbc_pkg.sv
// Shared types, constants and SHA-256 bit functions for the block compression engine.
`default_nettype none

package sbc_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned NumHashWords = 8;
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned WordCntW     = $clog2(BlockWords);
  localparam int unsigned NumRounds    = 64;
  localparam int unsigned RoundIdxW    = $clog2(NumRounds);
  localparam int unsigned InitIdxW     = $clog2(NumHashWords);
  localparam int unsigned CfgIdxW      = InitIdxW + 1;

  typedef logic [NumHashWords-1:0][WordW-1:0] sbc_words_t;

  // Index 0 is the first chaining word.
  localparam sbc_words_t InitHReset = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WordW-1:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             new_message;
  } sbc_in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_w0;
    logic [WordW-1:0] digest_w1;
    logic [WordW-1:0] digest_w2;
    logic [WordW-1:0] digest_w3;
    logic [WordW-1:0] digest_w4;
    logic [WordW-1:0] digest_w5;
    logic [WordW-1:0] digest_w6;
    logic [WordW-1:0] digest_w7;
  } sbc_out_t;

  // Control from the sequencer to the schedule window and the round unit.
  typedef struct packed {
    logic word_in;  // a message word is shifted into the schedule window
    logic load;     // working variables load from the chaining value
    logic step;     // one compression round is executed
  } sbc_ctrl_t;

  typedef enum logic [1:0] {
    SbcCollect,
    SbcRound,
    SbcFeed
  } sbc_state_e;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

`default_nettype wire

// File: rtl/sbc_sched.sv
// Sixteen-word message schedule window that shifts in message words and expanded words.
`default_nettype none

module sbc_sched (
  input  wire logic                    clk_i,
  input  wire sbc_pkg::sbc_ctrl_t      ctrl_i,
  input  wire logic [sbc_pkg::WordW-1:0] word_i,
  output logic      [sbc_pkg::WordW-1:0] w0_o
);
  import sbc_pkg::*;

  logic [BlockWords-1:0][WordW-1:0] win_q, win_d;
  logic [WordW-1:0]                 expand_w;

  // Entry 0 is the schedule word of the current round; the newest word sits at the top.
  assign expand_w = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

  always_comb begin
    win_d = win_q;
    if (ctrl_i.word_in) begin
      win_d = {word_i, win_q[BlockWords-1:1]};
    end else if (ctrl_i.step) begin
      win_d = {expand_w, win_q[BlockWords-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w0_o = win_q[0];

endmodule

`default_nettype wire

// File: rtl/sbc_round.sv
// Working variables a to h and the one-round-per-cycle compression datapath.
`default_nettype none

module sbc_round (
  input  wire logic                        clk_i,
  input  wire sbc_pkg::sbc_ctrl_t          ctrl_i,
  input  wire sbc_pkg::sbc_words_t         chain_i,
  input  wire logic [sbc_pkg::WordW-1:0]     w_i,
  input  wire logic [sbc_pkg::RoundIdxW-1:0] round_i,
  output sbc_pkg::sbc_words_t              vars_o
);
  import sbc_pkg::*;

  sbc_words_t       v_q, v_d;
  logic [WordW-1:0] t1, t2, choose, major;

  always_comb begin
    choose = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    major  = ((v_q[0] | v_q[1]) & v_q[2]) | (v_q[0] & v_q[1]);
    t1     = v_q[7] + big_sig1(v_q[4]) + choose + RoundK[round_i] + w_i;
    t2     = big_sig0(v_q[0]) + major;
  end

  always_comb begin
    v_d = v_q;
    if (ctrl_i.load) begin
      v_d = chain_i;
    end else if (ctrl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign vars_o = v_q;

endmodule

`default_nettype wire

// File: rtl/sha256_block_compress.sv
// Top level of the SHA-256 block compression engine: sequencer, chaining value and output word.
// After the sixteenth word of a block is accepted, the block runs through all 64 rounds on the
// single round unit, then the feed-forward, which waits while the previous digest is still held.
// Throughput: message words are taken one per cycle while a block is collected; no new words
// are taken while the 64 rounds and the feed-forward of a block run.
// Reset: the initial words and the chaining value return to the standard SHA-256 values,
// the word count clears and no digest is pending.
`default_nettype none

module sha256_block_compress (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Message words in.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sbc_pkg::sbc_in_t              in_word_i,
  // Digest words out.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sbc_pkg::sbc_out_t                  out_word_o,
  // Initial chaining word registers.
  input  wire logic                          cfg_we_i,
  input  wire logic [sbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sbc_pkg::WordW-1:0]     cfg_data_i
);
  import sbc_pkg::*;

  localparam logic [WordCntW-1:0]  WordLast  = WordCntW'(BlockWords - 1);
  localparam logic [RoundIdxW-1:0] RoundLast = RoundIdxW'(NumRounds - 1);

  sbc_state_e           state_q, state_d;
  logic [WordCntW-1:0]  word_count_q, word_count_d;
  logic [RoundIdxW-1:0] round_q, round_d;
  sbc_words_t           init_h_q;
  sbc_words_t           chain_q, chain_d;
  sbc_words_t           vars;
  sbc_words_t           sum;
  sbc_ctrl_t            ctrl;
  sbc_out_t             out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 in_fire, last_word, feed_fire;
  logic [WordW-1:0]     sched_w;

  // The message schedule window and the round unit share one control bundle.
  sbc_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .word_i (in_word_i.message_word),
    .w0_o   (sched_w)
  );

  sbc_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .chain_i (chain_q),
    .w_i     (sched_w),
    .round_i (round_q),
    .vars_o  (vars)
  );

  assign in_fire = in_valid_i && !in_stall_o;

  // A flagged word always begins a new block, so it can never be the last word of one.
  assign last_word = !in_word_i.new_message && (word_count_q == WordLast);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SbcCollect: begin
        if (in_fire && last_word) begin
          state_d = SbcRound;
        end
      end
      SbcRound: begin
        if (round_q == RoundLast) begin
          state_d = SbcFeed;
        end
      end
      SbcFeed: begin
        if (!(out_valid_q && out_stall_i)) begin
          state_d = SbcCollect;
        end
      end
      default: begin
        state_d = SbcCollect;
      end
    endcase
  end

  // Output decode of the sequencer. Words are only taken while a block is being collected;
  // the feed-forward waits when the previous digest has not been taken yet.
  always_comb begin
    in_stall_o   = 1'b1;
    feed_fire    = 1'b0;
    ctrl.step    = 1'b0;
    unique case (state_q)
      SbcCollect: begin
        in_stall_o = 1'b0;
      end
      SbcRound: begin
        ctrl.step = 1'b1;
      end
      SbcFeed: begin
        feed_fire = !(out_valid_q && out_stall_i);
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    ctrl.word_in = in_valid_i && !in_stall_o;
    ctrl.load    = ctrl.word_in && last_word;
  end

  // Feed-forward: the working variables are added back into the chaining value.
  always_comb begin
    for (int i = 0; i < NumHashWords; i++) begin
      sum[i] = chain_q[i] + vars[i];
    end
  end

  always_comb begin
    word_count_d = word_count_q;
    if (in_fire) begin
      if (in_word_i.new_message) begin
        word_count_d = WordCntW'(1);
      end else begin
        word_count_d = word_count_q + WordCntW'(1);
      end
    end
  end

  // The round counter runs only while rounds execute and is zero otherwise.
  assign round_d = ctrl.step ? round_q + RoundIdxW'(1) : '0;

  always_comb begin
    chain_d = chain_q;
    if (in_fire && in_word_i.new_message) begin
      chain_d = init_h_q;
    end else if (feed_fire) begin
      chain_d = sum;
    end
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || feed_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SbcCollect;
      word_count_q <= '0;
      round_q      <= '0;
      init_h_q     <= InitHReset;
      chain_q      <= InitHReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_count_q <= word_count_d;
      round_q      <= round_d;
      chain_q      <= chain_d;
      out_valid_q  <= out_valid_d;
      // Writes beyond the last initial word are dropped.
      if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumHashWords))) begin
        init_h_q[cfg_idx_i[InitIdxW-1:0]] <= cfg_data_i;
      end
    end
  end

  // The digest register is loaded only when it is free, so a held word never changes.
  always_ff @(posedge clk_i) begin
    if (feed_fire) begin
      out_q.digest_w0 <= sum[0];
      out_q.digest_w1 <= sum[1];
      out_q.digest_w2 <= sum[2];
      out_q.digest_w3 <= sum[3];
      out_q.digest_w4 <= sum[4];
      out_q.digest_w5 <= sum[5];
      out_q.digest_w6 <= sum[6];
      out_q.digest_w7 <= sum[7];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A digest only appears out of the feed-forward cycle.
  a_digest_from_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SbcFeed)
    else $error("digest became valid outside the feed-forward cycle");

  // Rounds always start from round zero.
  a_round_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SbcCollect && state_d == SbcRound) |=> (round_q == '0))
    else $error("round counter not zero at the start of a block");

  // Compression starts only on the sixteenth word of a block, which must be unflagged.
  a_start_on_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SbcCollect && state_d == SbcRound) |->
      (in_fire && !in_word_i.new_message && word_count_q == WordLast))
    else $error("compression started before a full block was collected");

  // The word count holds while a block is being compressed.
  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SbcCollect) |=> $stable(word_count_q))
    else $error("word count changed during compression");

  // The feed-forward never overwrites a digest that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed_fire |-> !(out_valid_q && out_stall_i))
    else $error("feed-forward overwrote a pending digest");

endmodule

`default_nettype wire
